@@ hw/rtl/srcp_pkg.sv @@
// Shared types, constants and helpers for the subtitle rectangle placer.
// Used by srcp_ctrl, srcp_dpath and the top level; depends on nothing.
package srcp_pkg;

    localparam int SLOTS = 16;
    localparam int CW    = 21;
    localparam int KW    = 16;
    localparam int LW    = 8;
    localparam int BW    = 16;
    localparam int IW    = $clog2(SLOTS);
    localparam int PW    = $clog2(SLOTS + 1);
    localparam int EW    = CW + 2;

    typedef enum logic [1:0] {
        CMD_PLACE  = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_PLACED = 2'd0,
        ST_CACHED = 2'd1,
        ST_FULL   = 2'd2,
        ST_DONE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_INPUT = 2'd1,
        RES_UNPAD = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     pad;
        logic     clear_all;
        logic     remove;
        logic     drop_key;
        logic     pass_init;
        logic     scan_start;
        logic     scan_step;
        logic     test;
        logic     push;
        logic     store;
        logic     emit;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic cache_hit;
        logic found;
        logic scan_last;
        logic moved;
        logic has_free;
    } dp_stat_t;

    // Clamp an extended value to the signed coordinate range.
    function automatic logic signed [CW-1:0] sat(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] cmax;
        logic signed [EW-1:0] cmin;
        cmax = {3'b000, {(CW - 1){1'b1}}};
        cmin = {3'b111, {(CW - 1){1'b0}}};
        if (v > cmax)
        begin
            return cmax[CW-1:0];
        end
        else if (v < cmin)
        begin
            return cmin[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    function automatic logic signed [EW-1:0] cext(input logic signed [CW-1:0] v);
        return {{2{v[CW-1]}}, v};
    endfunction

    function automatic logic signed [EW-1:0] bext(input logic [BW-1:0] v);
        return {{(EW - BW){1'b0}}, v};
    endfunction

endpackage

@@ hw/rtl/subtitle_rect_collision_placer.sv @@
// Top level of the subtitle rectangle placer: joins srcp_ctrl and srcp_dpath.
// Depends on srcp_pkg, srcp_ctrl and srcp_dpath.
//
// Usage: one input beat carries a command (place, remove by id, clear table)
// with an id, a layer, a requested rectangle, borders and push controls. Every
// beat yields exactly one result beat with a rectangle and a status code.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// A no-op goes straight to the result; clear and remove first update the table,
// and a place first pads the rectangle and checks for a cached copy. Any other
// place makes up to SLOTS+1 passes; each pass visits the stored entries in
// ascending id order. Finding each next entry starts a scan that steps through
// all SLOTS slots one at a time; an entry found is then tested and pushed.
// One item is in work at a time; the next is taken as soon as the current
// result is in the output register, even while that beat still waits.
// Reset empties the table at once and drops any pending result.
// When the receiver stalls, the result beat holds and the block waits before
// loading the next result.
module subtitle_rect_collision_placer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [srcp_pkg::KW-1:0]        sub_id,
    input  logic signed [srcp_pkg::LW-1:0] layer,
    input  logic signed [srcp_pkg::CW-1:0] in_left,
    input  logic signed [srcp_pkg::CW-1:0] in_top,
    input  logic signed [srcp_pkg::CW-1:0] in_right,
    input  logic signed [srcp_pkg::CW-1:0] in_bottom,
    input  logic [srcp_pkg::BW-1:0]        border_tl,
    input  logic [srcp_pkg::BW-1:0]        border_br,
    input  logic                           vertical,
    input  logic                           push_forward,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [srcp_pkg::CW-1:0] out_left,
    output logic signed [srcp_pkg::CW-1:0] out_top,
    output logic signed [srcp_pkg::CW-1:0] out_right,
    output logic signed [srcp_pkg::CW-1:0] out_bottom,
    output logic [1:0]                     status
);

    srcp_pkg::dp_cmd_t  dcmd;
    srcp_pkg::dp_stat_t dstat;

    srcp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .dcmd      (dcmd),
        .dstat     (dstat)
    );

    srcp_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .dcmd         (dcmd),
        .dstat        (dstat),
        .sub_id       (sub_id),
        .layer        (layer),
        .in_left      (in_left),
        .in_top       (in_top),
        .in_right     (in_right),
        .in_bottom    (in_bottom),
        .border_tl    (border_tl),
        .border_br    (border_br),
        .vertical     (vertical),
        .push_forward (push_forward),
        .out_left     (out_left),
        .out_top      (out_top),
        .out_right    (out_right),
        .out_bottom   (out_bottom)
    );

endmodule

@@ hw/rtl/srcp_ctrl.sv @@
// Sequencing state machine for the subtitle rectangle placer.
// Depends on srcp_pkg; drives srcp_dpath through command and status structs.
module srcp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output srcp_pkg::dp_cmd_t   dcmd,
    input  srcp_pkg::dp_stat_t  dstat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_REMOVE,
        S_PAD,
        S_CACHE,
        S_PASS_INIT,
        S_SCAN_START,
        S_SCAN,
        S_CHECK,
        S_PUSH,
        S_STORE,
        S_RESULT
    } state_t;

    state_t                     state_reg, state_next;
    srcp_pkg::status_t          status_reg, status_next;
    srcp_pkg::status_t          out_status_reg, out_status_next;
    srcp_pkg::res_sel_t         sel_reg, sel_next;
    logic [srcp_pkg::PW-1:0]    pass_reg, pass_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        out_status_next = out_status_reg;
        sel_next        = sel_reg;
        pass_next       = pass_reg;
        out_valid_next  = out_valid_reg && out_stall;
        dcmd            = '0;
        dcmd.res_sel    = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dcmd.load   = 1'b1;
                    status_next = srcp_pkg::ST_DONE;
                    sel_next    = srcp_pkg::RES_ZERO;
                    unique case (srcp_pkg::cmd_t'(cmd))
                        srcp_pkg::CMD_PLACE:  state_next = S_PAD;
                        srcp_pkg::CMD_REMOVE: state_next = S_REMOVE;
                        srcp_pkg::CMD_CLEAR:  state_next = S_CLEAR;
                        default:              state_next = S_RESULT;
                    endcase
                end
            end
            S_CLEAR:
            begin
                dcmd.clear_all = 1'b1;
                state_next     = S_RESULT;
            end
            S_REMOVE:
            begin
                dcmd.remove = 1'b1;
                state_next  = S_RESULT;
            end
            S_PAD:
            begin
                dcmd.pad   = 1'b1;
                state_next = S_CACHE;
            end
            S_CACHE:
            begin
                if (dstat.cache_hit)
                begin
                    status_next = srcp_pkg::ST_CACHED;
                    sel_next    = srcp_pkg::RES_INPUT;
                    state_next  = S_RESULT;
                end
                else
                begin
                    dcmd.drop_key = 1'b1;
                    pass_next     = '0;
                    state_next    = S_PASS_INIT;
                end
            end
            S_PASS_INIT:
            begin
                dcmd.pass_init = 1'b1;
                state_next     = S_SCAN_START;
            end
            S_SCAN_START:
            begin
                dcmd.scan_start = 1'b1;
                state_next      = S_SCAN;
            end
            S_SCAN:
            begin
                dcmd.scan_step = 1'b1;
                if (dstat.scan_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (dstat.found)
                begin
                    dcmd.test  = 1'b1;
                    state_next = S_PUSH;
                end
                else if (dstat.moved && (pass_reg < srcp_pkg::PW'(srcp_pkg::SLOTS)))
                begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = S_PASS_INIT;
                end
                else
                begin
                    state_next = S_STORE;
                end
            end
            S_PUSH:
            begin
                dcmd.push  = 1'b1;
                state_next = S_SCAN_START;
            end
            S_STORE:
            begin
                dcmd.store  = 1'b1;
                status_next = dstat.has_free ? srcp_pkg::ST_PLACED : srcp_pkg::ST_FULL;
                sel_next    = srcp_pkg::RES_UNPAD;
                state_next  = S_RESULT;
            end
            S_RESULT:
            begin
                // The result register is loaded only once the previous beat has gone.
                if (out_free)
                begin
                    dcmd.emit       = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            status_reg     <= srcp_pkg::ST_DONE;
            out_status_reg <= srcp_pkg::ST_DONE;
            sel_reg        <= srcp_pkg::RES_ZERO;
            pass_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            status_reg     <= status_next;
            out_status_reg <= out_status_next;
            sel_reg        <= sel_next;
            pass_reg       <= pass_next;
            out_valid_reg  <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_valid_reg && out_stall) |=> (state_reg == S_RESULT))
        else $error("result state left while output beat still pending");
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pass_reg <= srcp_pkg::PW'(srcp_pkg::SLOTS))
        else $error("pass counter beyond bound");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        dcmd.emit |-> out_free)
        else $error("result loaded over a pending beat");
`endif

endmodule

@@ hw/rtl/srcp_dpath.sv @@
// Datapath of the subtitle rectangle placer: slot table, working rectangle,
// key-order scan and push arithmetic. Depends on srcp_pkg.
module srcp_dpath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  srcp_pkg::dp_cmd_t              dcmd,
    output srcp_pkg::dp_stat_t             dstat,
    input  logic [srcp_pkg::KW-1:0]        sub_id,
    input  logic signed [srcp_pkg::LW-1:0] layer,
    input  logic signed [srcp_pkg::CW-1:0] in_left,
    input  logic signed [srcp_pkg::CW-1:0] in_top,
    input  logic signed [srcp_pkg::CW-1:0] in_right,
    input  logic signed [srcp_pkg::CW-1:0] in_bottom,
    input  logic [srcp_pkg::BW-1:0]        border_tl,
    input  logic [srcp_pkg::BW-1:0]        border_br,
    input  logic                           vertical,
    input  logic                           push_forward,
    output logic signed [srcp_pkg::CW-1:0] out_left,
    output logic signed [srcp_pkg::CW-1:0] out_top,
    output logic signed [srcp_pkg::CW-1:0] out_right,
    output logic signed [srcp_pkg::CW-1:0] out_bottom
);

    localparam int SLOTS = srcp_pkg::SLOTS;
    localparam int CW    = srcp_pkg::CW;
    localparam int IW    = srcp_pkg::IW;

    // Slot table
    logic [SLOTS-1:0]              valid_reg, valid_next;
    logic [srcp_pkg::KW-1:0]       slot_key [SLOTS];
    logic signed [srcp_pkg::LW-1:0] slot_layer [SLOTS];
    logic signed [CW-1:0]          slot_left [SLOTS];
    logic signed [CW-1:0]          slot_top [SLOTS];
    logic signed [CW-1:0]          slot_right [SLOTS];
    logic signed [CW-1:0]          slot_bottom [SLOTS];

    // Captured request
    logic [srcp_pkg::KW-1:0]        key_reg;
    logic signed [srcp_pkg::LW-1:0] layer_reg;
    logic signed [CW-1:0]           il_reg, it_reg, ir_reg, ib_reg;
    logic [srcp_pkg::BW-1:0]        tlb_reg, brb_reg;
    logic                           vert_reg, fwd_reg;

    // Working rectangle
    logic signed [CW-1:0] l_reg, t_reg, r_reg, b_reg;
    logic signed [CW-1:0] l_next, t_next, r_next, b_next;

    // Scan control
    logic                    prev_any_reg;
    logic [srcp_pkg::KW-1:0] prev_key_reg;
    logic [IW-1:0]           idx_reg;
    logic [IW-1:0]           best_idx_reg;
    logic [srcp_pkg::KW-1:0] best_key_reg;
    logic                    found_reg;
    logic                    moved_reg;
    logic                    ovl_reg;

    logic                    cand;
    logic [SLOTS-1:0]        key_hit;
    logic                    cache_hit;
    logic                    has_free;
    logic [IW-1:0]           free_idx;
    logic signed [CW-1:0]    sl, st, sr, sb;
    logic signed [CW-1:0]    mx_l, mn_r, mx_t, mn_b;
    logic                    overlap;
    logic signed [srcp_pkg::EW-1:0] span_w, span_h;

    always_comb
    begin
        cache_hit = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            key_hit[i] = valid_reg[i] && (slot_key[i] == key_reg);
            if (key_hit[i] && slot_left[i] == l_reg && slot_top[i] == t_reg &&
                slot_right[i] == r_reg && slot_bottom[i] == b_reg)
            begin
                cache_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        has_free = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                has_free = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    // A slot is a candidate when it holds a key above the last one visited and
    // below the best seen so far in this scan.
    assign cand = valid_reg[idx_reg] &&
                  (!prev_any_reg || slot_key[idx_reg] > prev_key_reg) &&
                  (!found_reg || slot_key[idx_reg] < best_key_reg);

    assign sl = slot_left[best_idx_reg];
    assign st = slot_top[best_idx_reg];
    assign sr = slot_right[best_idx_reg];
    assign sb = slot_bottom[best_idx_reg];

    assign mx_l    = (l_reg > sl) ? l_reg : sl;
    assign mn_r    = (r_reg < sr) ? r_reg : sr;
    assign mx_t    = (t_reg > st) ? t_reg : st;
    assign mn_b    = (b_reg < sb) ? b_reg : sb;
    assign overlap = (slot_layer[best_idx_reg] == layer_reg) && (mx_l < mn_r) && (mx_t < mn_b);

    assign span_w = srcp_pkg::cext(r_reg) - srcp_pkg::cext(l_reg);
    assign span_h = srcp_pkg::cext(b_reg) - srcp_pkg::cext(t_reg);

    always_comb
    begin
        l_next = l_reg;
        t_next = t_reg;
        r_next = r_reg;
        b_next = b_reg;
        if (dcmd.pad)
        begin
            l_next = srcp_pkg::sat(srcp_pkg::cext(il_reg) - srcp_pkg::bext(tlb_reg));
            t_next = srcp_pkg::sat(srcp_pkg::cext(it_reg) - srcp_pkg::bext(tlb_reg));
            r_next = srcp_pkg::sat(srcp_pkg::cext(ir_reg) + srcp_pkg::bext(brb_reg));
            b_next = srcp_pkg::sat(srcp_pkg::cext(ib_reg) + srcp_pkg::bext(brb_reg));
        end
        else if (dcmd.push && ovl_reg)
        begin
            if (vert_reg)
            begin
                if (fwd_reg)
                begin
                    r_next = srcp_pkg::sat(srcp_pkg::cext(sr) + span_w);
                    l_next = sr;
                end
                else
                begin
                    l_next = srcp_pkg::sat(srcp_pkg::cext(sl) - span_w);
                    r_next = sl;
                end
            end
            else
            begin
                if (fwd_reg)
                begin
                    b_next = srcp_pkg::sat(srcp_pkg::cext(sb) + span_h);
                    t_next = sb;
                end
                else
                begin
                    t_next = srcp_pkg::sat(srcp_pkg::cext(st) - span_h);
                    b_next = st;
                end
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (dcmd.clear_all)
        begin
            valid_next = '0;
        end
        else if (dcmd.remove || dcmd.drop_key)
        begin
            valid_next = valid_reg & ~key_hit;
        end
        else if (dcmd.store && has_free)
        begin
            valid_next[free_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            prev_any_reg <= 1'b0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            moved_reg    <= 1'b0;
            ovl_reg      <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (dcmd.pass_init)
            begin
                prev_any_reg <= 1'b0;
                moved_reg    <= 1'b0;
            end
            if (dcmd.scan_start)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (dcmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (cand)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (dcmd.test)
            begin
                prev_any_reg <= 1'b1;
                ovl_reg      <= overlap;
            end
            if (dcmd.push && ovl_reg)
            begin
                moved_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.load)
        begin
            key_reg   <= sub_id;
            layer_reg <= layer;
            il_reg    <= in_left;
            it_reg    <= in_top;
            ir_reg    <= in_right;
            ib_reg    <= in_bottom;
            tlb_reg   <= border_tl;
            brb_reg   <= border_br;
            vert_reg  <= vertical;
            fwd_reg   <= push_forward;
        end
        l_reg <= l_next;
        t_reg <= t_next;
        r_reg <= r_next;
        b_reg <= b_next;
        if (dcmd.scan_step && cand)
        begin
            best_idx_reg <= idx_reg;
            best_key_reg <= slot_key[idx_reg];
        end
        if (dcmd.test)
        begin
            prev_key_reg <= best_key_reg;
        end
        if (dcmd.store && has_free)
        begin
            slot_key[free_idx]    <= key_reg;
            slot_layer[free_idx]  <= layer_reg;
            slot_left[free_idx]   <= l_reg;
            slot_top[free_idx]    <= t_reg;
            slot_right[free_idx]  <= r_reg;
            slot_bottom[free_idx] <= b_reg;
        end
        if (dcmd.emit)
        begin
            case (dcmd.res_sel)
                srcp_pkg::RES_INPUT:
                begin
                    out_left   <= il_reg;
                    out_top    <= it_reg;
                    out_right  <= ir_reg;
                    out_bottom <= ib_reg;
                end
                srcp_pkg::RES_UNPAD:
                begin
                    out_left   <= srcp_pkg::sat(srcp_pkg::cext(l_reg) + srcp_pkg::bext(tlb_reg));
                    out_top    <= srcp_pkg::sat(srcp_pkg::cext(t_reg) + srcp_pkg::bext(tlb_reg));
                    out_right  <= srcp_pkg::sat(srcp_pkg::cext(r_reg) - srcp_pkg::bext(brb_reg));
                    out_bottom <= srcp_pkg::sat(srcp_pkg::cext(b_reg) - srcp_pkg::bext(brb_reg));
                end
                default:
                begin
                    out_left   <= '0;
                    out_top    <= '0;
                    out_right  <= '0;
                    out_bottom <= '0;
                end
            endcase
        end
    end

    assign dstat.cache_hit = cache_hit;
    assign dstat.found     = found_reg;
    assign dstat.scan_last = (idx_reg == IW'(SLOTS - 1));
    assign dstat.moved     = moved_reg;
    assign dstat.has_free  = has_free;

endmodule
